// ----- sv/rmd_pkg.sv -----
// ----------------------------------------------------------------------------
// rmd_pkg
// shared types, constants and step tables of the ripemd-160 hash engine
// ----------------------------------------------------------------------------
package rmd_pkg;

  typedef enum logic [0:0] {
    REQ_DATA   = 1'b0,
    REQ_FINISH = 1'b1
  } req_t;

  typedef struct packed {
    logic       finish;
    logic [7:0] data;
  } cmd_t;

  localparam logic [31:0] H0_INIT = 32'h67452301;
  localparam logic [31:0] H1_INIT = 32'hEFCDAB89;
  localparam logic [31:0] H2_INIT = 32'h98BADCFE;
  localparam logic [31:0] H3_INIT = 32'h10325476;
  localparam logic [31:0] H4_INIT = 32'hC3D2E1F0;

  localparam logic [7:0] PAD_BYTE  = 8'h80;
  localparam logic [5:0] LEN_START = 6'd56;

  function automatic logic [3:0] sel_l(input logic [6:0] j);
    logic [3:0] t [80];
    t = '{4'd0,4'd1,4'd2,4'd3,4'd4,4'd5,4'd6,4'd7,4'd8,4'd9,4'd10,4'd11,4'd12,4'd13,4'd14,
          4'd15,
          4'd7,4'd4,4'd13,4'd1,4'd10,4'd6,4'd15,4'd3,4'd12,4'd0,4'd9,4'd5,4'd2,4'd14,4'd11,
          4'd8,
          4'd3,4'd10,4'd14,4'd4,4'd9,4'd15,4'd8,4'd1,4'd2,4'd7,4'd0,4'd6,4'd13,4'd11,4'd5,
          4'd12,
          4'd1,4'd9,4'd11,4'd10,4'd0,4'd8,4'd12,4'd4,4'd13,4'd3,4'd7,4'd15,4'd14,4'd5,4'd6,
          4'd2,
          4'd4,4'd0,4'd5,4'd9,4'd7,4'd12,4'd2,4'd10,4'd14,4'd1,4'd3,4'd8,4'd11,4'd6,4'd15,
          4'd13};
    return (j < 7'd80) ? t[j] : 4'd0;
  endfunction

  function automatic logic [3:0] sel_r(input logic [6:0] j);
    logic [3:0] t [80];
    t = '{4'd5,4'd14,4'd7,4'd0,4'd9,4'd2,4'd11,4'd4,4'd13,4'd6,4'd15,4'd8,4'd1,4'd10,4'd3,
          4'd12,
          4'd6,4'd11,4'd3,4'd7,4'd0,4'd13,4'd5,4'd10,4'd14,4'd15,4'd8,4'd12,4'd4,4'd9,4'd1,
          4'd2,
          4'd15,4'd5,4'd1,4'd3,4'd7,4'd14,4'd6,4'd9,4'd11,4'd8,4'd12,4'd2,4'd10,4'd0,4'd4,
          4'd13,
          4'd8,4'd6,4'd4,4'd1,4'd3,4'd11,4'd15,4'd0,4'd5,4'd12,4'd2,4'd13,4'd9,4'd7,4'd10,
          4'd14,
          4'd12,4'd15,4'd10,4'd4,4'd1,4'd5,4'd8,4'd7,4'd6,4'd2,4'd13,4'd14,4'd0,4'd3,4'd9,
          4'd11};
    return (j < 7'd80) ? t[j] : 4'd0;
  endfunction

  function automatic logic [4:0] rot_l(input logic [6:0] j);
    logic [4:0] t [80];
    t = '{5'd11,5'd14,5'd15,5'd12,5'd5,5'd8,5'd7,5'd9,5'd11,5'd13,5'd14,5'd15,5'd6,5'd7,
          5'd9,5'd8,
          5'd7,5'd6,5'd8,5'd13,5'd11,5'd9,5'd7,5'd15,5'd7,5'd12,5'd15,5'd9,5'd11,5'd7,
          5'd13,5'd12,
          5'd11,5'd13,5'd6,5'd7,5'd14,5'd9,5'd13,5'd15,5'd14,5'd8,5'd13,5'd6,5'd5,5'd12,
          5'd7,5'd5,
          5'd11,5'd12,5'd14,5'd15,5'd14,5'd15,5'd9,5'd8,5'd9,5'd14,5'd5,5'd6,5'd8,5'd6,
          5'd5,5'd12,
          5'd9,5'd15,5'd5,5'd11,5'd6,5'd8,5'd13,5'd12,5'd5,5'd12,5'd13,5'd14,5'd11,5'd8,
          5'd5,5'd6};
    return (j < 7'd80) ? t[j] : 5'd0;
  endfunction

  function automatic logic [4:0] rot_r(input logic [6:0] j);
    logic [4:0] t [80];
    t = '{5'd8,5'd9,5'd9,5'd11,5'd13,5'd15,5'd15,5'd5,5'd7,5'd7,5'd8,5'd11,5'd14,5'd14,
          5'd12,5'd6,
          5'd9,5'd13,5'd15,5'd7,5'd12,5'd8,5'd9,5'd11,5'd7,5'd7,5'd12,5'd7,5'd6,5'd15,
          5'd13,5'd11,
          5'd9,5'd7,5'd15,5'd11,5'd8,5'd6,5'd6,5'd14,5'd12,5'd13,5'd5,5'd14,5'd13,5'd13,
          5'd7,5'd5,
          5'd15,5'd5,5'd8,5'd11,5'd14,5'd14,5'd6,5'd14,5'd6,5'd9,5'd12,5'd9,5'd12,5'd5,
          5'd15,5'd8,
          5'd8,5'd5,5'd12,5'd9,5'd12,5'd5,5'd14,5'd6,5'd8,5'd13,5'd6,5'd5,5'd15,5'd13,
          5'd11,5'd11};
    return (j < 7'd80) ? t[j] : 5'd0;
  endfunction

  function automatic logic [31:0] add_l(input logic [2:0] rd);
    case (rd)
      3'd0: return 32'h00000000;
      3'd1: return 32'h5A827999;
      3'd2: return 32'h6ED9EBA1;
      3'd3: return 32'h8F1BBCDC;
      default: return 32'hA953FD4E;
    endcase
  endfunction

  function automatic logic [31:0] add_r(input logic [2:0] rd);
    case (rd)
      3'd0: return 32'h50A28BE6;
      3'd1: return 32'h5C4DD124;
      3'd2: return 32'h6D703EF3;
      3'd3: return 32'h7A6D76E9;
      default: return 32'h00000000;
    endcase
  endfunction

  function automatic logic [31:0] mix(input logic [2:0] rd, input logic [31:0] x,
                                      input logic [31:0] y, input logic [31:0] z);
    case (rd)
      3'd0: return x ^ y ^ z;
      3'd1: return (x & y) | (~x & z);
      3'd2: return (x | ~y) ^ z;
      3'd3: return (x & z) | (y & ~z);
      default: return x ^ (y | ~z);
    endcase
  endfunction

  function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] d;
    d = {x, x} << n;
    return d[63:32];
  endfunction

endpackage

// ----- sv/rmd_cmd_fifo.sv -----
// ----------------------------------------------------------------------------
// rmd_cmd_fifo
// short queue of request items between the front and the compression back end
// ----------------------------------------------------------------------------
module rmd_cmd_fifo import rmd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t wdata,
  output logic full,
  input  logic pop,
  output cmd_t rdata,
  output logic empty
);
  cmd_t       mem [4];
  logic [1:0] wptr;
  logic [1:0] rptr;
  logic [2:0] count;

  assign full  = (count == 3'd4);
  assign empty = (count == 3'd0);
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push && !full) begin
        wptr <= wptr + 2'd1;
      end
      if (pop && !empty) begin
        rptr <= rptr + 2'd1;
      end
      count <= count + 3'((push && !full) ? 1 : 0) - 3'((pop && !empty) ? 1 : 0);
    end
  end
endmodule

// ----- sv/rmd_core.sv -----
// ----------------------------------------------------------------------------
// rmd_core
// byte packing, padding, 80-step two-line compression and digest output
// ----------------------------------------------------------------------------
module rmd_core import rmd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cmd_valid,
  input  cmd_t        cmd,
  output logic        cmd_pop,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word,
  output logic        empty,
  input  logic        pop
);
  typedef enum logic [2:0] {
    ST_IDLE, ST_PAD, ST_LEN, ST_COMP, ST_FOLD, ST_OUT
  } state_t;

  state_t      state, state_next;
  logic [31:0] blk [16];
  logic [31:0] h [5];
  logic [31:0] l [5];
  logic [31:0] r [5];
  logic [5:0]  fill;
  logic [63:0] bits;
  logic [6:0]  step;
  logic        fin;
  logic [2:0]  oidx;

  logic        put;
  logic [7:0]  put_byte;
  logic [2:0]  rd;
  logic [31:0] tl, tr;
  logic        pad_first;
  logic [63:0] len_reg;
  logic        out_done;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          if (cmd.finish) begin
            state_next = ST_PAD;
          end else if (fill == 6'd63) begin
            state_next = ST_COMP;
          end
        end
      end
      ST_PAD: begin
        if (fill == 6'd63) begin
          state_next = ST_COMP;
        end else if (fill == LEN_START - 6'd1) begin
          state_next = ST_LEN;
        end
      end
      ST_LEN:  state_next = ST_COMP;
      ST_COMP: if (step == 7'd79) state_next = ST_FOLD;
      ST_FOLD: begin
        if (!fin) begin
          state_next = ST_IDLE;
        end else if (out_done) begin
          state_next = ST_OUT;
        end else begin
          state_next = ST_PAD;
        end
      end
      ST_OUT: if (pop && oidx == 3'd4) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop  = 1'b0;
    put      = 1'b0;
    put_byte = cmd.data;
    case (state)
      ST_IDLE: begin
        cmd_pop = cmd_valid;
        put     = cmd_valid && !cmd.finish;
      end
      ST_PAD: begin
        put      = 1'b1;
        put_byte = pad_first ? PAD_BYTE : 8'h00;
      end
      default: ;
    endcase
  end

  assign rd = (step >> 4) > 7'd4 ? 3'd4 : 3'(step >> 4);
  assign tl = rotl(l[0] + mix(rd, l[1], l[2], l[3]) + blk[sel_l(step)] + add_l(rd),
                   rot_l(step)) + l[4];
  assign tr = rotl(r[0] + mix(3'd4 - rd, r[1], r[2], r[3]) + blk[sel_r(step)] + add_r(rd),
                   rot_r(step)) + r[4];

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      fill      <= '0;
      bits      <= '0;
      step      <= '0;
      fin       <= 1'b0;
      oidx      <= '0;
      pad_first <= 1'b1;
      out_done  <= 1'b0;
      h[0] <= H0_INIT; h[1] <= H1_INIT; h[2] <= H2_INIT; h[3] <= H3_INIT; h[4] <= H4_INIT;
    end else begin
      state <= state_next;
      if (state == ST_IDLE && cmd_valid && cmd.finish) begin
        fin       <= 1'b1;
        pad_first <= 1'b1;
        len_reg   <= bits;
        out_done  <= 1'b0;
      end
      if (put) begin
        if (fill[1:0] == 2'd0) begin
          blk[fill[5:2]] <= {24'd0, put_byte};
        end else begin
          blk[fill[5:2]] <= blk[fill[5:2]] | (32'(put_byte) << {fill[1:0], 3'd0});
        end
        fill <= fill + 6'd1;
        if (state == ST_IDLE) begin
          bits <= bits + 64'd8;
        end else begin
          pad_first <= 1'b0;
        end
      end
      if (state == ST_LEN) begin
        blk[14] <= len_reg[31:0];
        blk[15] <= len_reg[63:32];
        fill    <= '0;
        out_done <= 1'b1;
      end
      if ((state == ST_IDLE && cmd_valid && !cmd.finish && fill == 6'd63) ||
          (state == ST_PAD && fill == 6'd63) || state == ST_LEN) begin
        l[0] <= h[0]; l[1] <= h[1]; l[2] <= h[2]; l[3] <= h[3]; l[4] <= h[4];
        r[0] <= h[0]; r[1] <= h[1]; r[2] <= h[2]; r[3] <= h[3]; r[4] <= h[4];
        step <= '0;
      end
      if (state == ST_COMP) begin
        l[0] <= l[4]; l[4] <= l[3]; l[3] <= rotl(l[2], 5'd10); l[2] <= l[1]; l[1] <= tl;
        r[0] <= r[4]; r[4] <= r[3]; r[3] <= rotl(r[2], 5'd10); r[2] <= r[1]; r[1] <= tr;
        step <= step + 7'd1;
      end
      if (state == ST_FOLD) begin
        h[0] <= h[1] + l[2] + r[3];
        h[1] <= h[2] + l[3] + r[4];
        h[2] <= h[3] + l[4] + r[0];
        h[3] <= h[4] + l[0] + r[1];
        h[4] <= h[0] + l[1] + r[2];
        step <= '0;
        if (fin && out_done) begin
          oidx <= '0;
        end
      end
      if (state == ST_OUT && pop) begin
        if (oidx == 3'd4) begin
          oidx <= '0;
          fin  <= 1'b0;
          bits <= '0;
          fill <= '0;
          h[0] <= H0_INIT; h[1] <= H1_INIT; h[2] <= H2_INIT; h[3] <= H3_INIT;
          h[4] <= H4_INIT;
        end else begin
          oidx <= oidx + 3'd1;
        end
      end
    end
  end

  assign empty       = !(state == ST_OUT);
  assign digest_word = h[oidx];
  assign word_index  = oidx;
  assign last_word   = (oidx == 3'd4);
endmodule

// ----- sv/ripemd160_hash_engine.sv -----
// ----------------------------------------------------------------------------
// ripemd160_hash_engine
// ripemd-160 hash of a byte stream, digest as five 32-bit words
// ----------------------------------------------------------------------------
//  channel  handshake     fields
//  input    push / full   req_type, data_byte
//  result   pop / empty   digest_word, word_index, last_word
//
//  a data item is packed into the current block; the 64th byte of a block starts
//  the 80-step compression and the chaining update, one step per cycle
//  finish pads one byte per cycle, then compresses one or two blocks
//  items queue in a four-entry buffer while the back end is busy
//  synchronous reset restores the initial chaining words
module ripemd160_hash_engine import rmd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic        req_type,
  input  logic [7:0]  data_byte,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);
  cmd_t wcmd, rcmd;
  logic q_empty, q_pop;

  assign wcmd.finish = req_type;
  assign wcmd.data   = data_byte;

  rmd_cmd_fifo u_fifo (
    .clk(clk), .rst(rst), .push(push), .wdata(wcmd), .full(full),
    .pop(q_pop), .rdata(rcmd), .empty(q_empty)
  );

  rmd_core u_core (
    .clk(clk), .rst(rst), .cmd_valid(!q_empty), .cmd(rcmd), .cmd_pop(q_pop),
    .digest_word(digest_word), .word_index(word_index), .last_word(last_word),
    .empty(empty), .pop(pop)
  );
endmodule
